@@ design/bsbq_pkg.sv @@
package bsbq_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 16;
    localparam int TAG_W      = 8;
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    // command codes
    localparam logic [1:0] CMD_ADD       = 2'd0;
    localparam logic [1:0] CMD_REMOVE    = 2'd1;
    localparam logic [1:0] CMD_BOTTOM    = 2'd2;
    localparam logic [1:0] CMD_INTERSECT = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS:0]   t_wide;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [IDX_W-1:0]             t_index;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec3;

    // one stored box
    typedef struct packed {
        t_vec3              lo;
        t_vec3              hi;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // command operands, broadcast to every cell
    typedef struct packed {
        logic [1:0]         cmd;
        logic [TAG_W-1:0]   tag;
        t_vec3              lo;
        t_vec3              hi;
        t_vec3              off;
    } t_query;

    // token that walks the chain, one cell per cycle
    typedef struct packed {
        logic   valid;
        logic   have;
        logic   found;
        logic   hit;
        t_vec3  lo;
        t_vec3  hi;
        t_coord bz;
    } t_tok;

    function automatic t_coord cmin(input t_coord a, input t_coord b);
        return (b < a) ? b : a;
    endfunction

    function automatic t_coord cmax(input t_coord a, input t_coord b);
        return (b > a) ? b : a;
    endfunction

    function automatic t_wide widen(input t_coord v);
        return t_wide'(v);
    endfunction

endpackage

@@ design/bsbq_cell.sv @@
module bsbq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsbq_pkg::t_index i_index,
    input  bsbq_pkg::t_count i_count,
    input  bsbq_pkg::t_query i_qry,
    input  logic            i_wr,
    input  logic            i_shift,
    input  bsbq_pkg::t_entry i_next_entry,
    output bsbq_pkg::t_entry o_entry,
    input  bsbq_pkg::t_tok   i_tok,
    output bsbq_pkg::t_tok   o_tok
);

    bsbq_pkg::t_entry r_entry;
    bsbq_pkg::t_tok   r_tok;
    bsbq_pkg::t_tok   n_tok;
    logic             r_del;
    logic             live;
    logic             match;
    logic             ov_xy;
    logic             ov_3d;

    assign live = bsbq_pkg::t_count'(i_index) < i_count;

    // hold the box; take a new one on add, or the neighbour's on compaction
    always_ff @(posedge i_clk) begin
        if (i_wr && (bsbq_pkg::t_count'(i_index) == i_count)) begin
            r_entry <= '{lo: i_qry.lo, hi: i_qry.hi, tag: i_qry.tag};
        end else if (i_shift && r_del) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;

    // overlap tests against this cell's box
    assign ov_xy = (r_entry.hi.x >= i_qry.lo.x) && (r_entry.lo.x <= i_qry.hi.x) &&
                   (r_entry.hi.y >= i_qry.lo.y) && (r_entry.lo.y <= i_qry.hi.y);

    assign ov_3d =
        ((bsbq_pkg::widen(r_entry.lo.x) + bsbq_pkg::widen(i_qry.off.x))
            < bsbq_pkg::widen(i_qry.hi.x)) &&
        ((bsbq_pkg::widen(r_entry.hi.x) + bsbq_pkg::widen(i_qry.off.x))
            > bsbq_pkg::widen(i_qry.lo.x)) &&
        ((bsbq_pkg::widen(r_entry.lo.y) + bsbq_pkg::widen(i_qry.off.y))
            < bsbq_pkg::widen(i_qry.hi.y)) &&
        ((bsbq_pkg::widen(r_entry.hi.y) + bsbq_pkg::widen(i_qry.off.y))
            > bsbq_pkg::widen(i_qry.lo.y)) &&
        ((bsbq_pkg::widen(r_entry.lo.z) + bsbq_pkg::widen(i_qry.off.z))
            < bsbq_pkg::widen(i_qry.hi.z)) &&
        ((bsbq_pkg::widen(r_entry.hi.z) + bsbq_pkg::widen(i_qry.off.z))
            > bsbq_pkg::widen(i_qry.lo.z));

    assign match = live && (i_qry.cmd == bsbq_pkg::CMD_REMOVE) && !i_tok.found &&
                   (r_entry.tag == i_qry.tag);

    // fold this cell's box into the passing token
    always_comb begin
        n_tok = i_tok;
        case (i_qry.cmd)
            bsbq_pkg::CMD_REMOVE: begin
                n_tok.found = i_tok.found || match;
                if (live && !match) begin
                    n_tok.have = 1'b1;
                    if (!i_tok.have) begin
                        n_tok.lo = r_entry.lo;
                        n_tok.hi = r_entry.hi;
                    end else begin
                        n_tok.lo.x = bsbq_pkg::cmin(i_tok.lo.x, r_entry.lo.x);
                        n_tok.lo.y = bsbq_pkg::cmin(i_tok.lo.y, r_entry.lo.y);
                        n_tok.lo.z = bsbq_pkg::cmin(i_tok.lo.z, r_entry.lo.z);
                        n_tok.hi.x = bsbq_pkg::cmax(i_tok.hi.x, r_entry.hi.x);
                        n_tok.hi.y = bsbq_pkg::cmax(i_tok.hi.y, r_entry.hi.y);
                        n_tok.hi.z = bsbq_pkg::cmax(i_tok.hi.z, r_entry.hi.z);
                    end
                end
            end
            bsbq_pkg::CMD_BOTTOM: begin
                if (live && ov_xy && (i_tok.bz > r_entry.lo.z)) begin
                    n_tok.bz = r_entry.lo.z;
                end
            end
            bsbq_pkg::CMD_INTERSECT: begin
                if (live && ov_3d) begin
                    n_tok.hit = 1'b1;
                end
            end
            default: begin
                n_tok = i_tok;
            end
        endcase
    end

    // advance the token; mark cells at or past a removed entry for compaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_del       <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            if (i_tok.valid) begin
                r_del       <= n_tok.found;
                r_tok.have  <= n_tok.have;
                r_tok.found <= n_tok.found;
                r_tok.hit   <= n_tok.hit;
                r_tok.lo    <= n_tok.lo;
                r_tok.hi    <= n_tok.hi;
                r_tok.bz    <= n_tok.bz;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

@@ design/box_set_bounds_and_queries_top.sv @@
// Add: the issue state forms the result, which then strobes from the registered valid.
// Remove, bottom and intersect: the issue state launches a query token that walks the chain
// of MAX_BOXES cells, one cell per cycle; the result strobes once the token leaves the last cell.
// busy is high from acceptance until the result is issued; start is taken again in the
// strobe cycle. The receiver cannot stall: each result is shown for one cycle only.
// Reset (synchronous, active low) clears count, bounds and control; box contents are undefined.
module box_set_bounds_and_queries_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_cmd,
    input  logic [bsbq_pkg::TAG_W-1:0]      i_part_id,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_min_x,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_min_y,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_min_z,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_max_x,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_max_y,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_max_z,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_off_x,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_off_y,
    input  logic signed [bsbq_pkg::COORD_BITS-1:0] i_off_z,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic                            o_hit,
    output logic signed [bsbq_pkg::COORD_BITS-1:0] o_bottom_z,
    output logic signed [bsbq_pkg::COORD_BITS-1:0] o_bound_min_x,
    output logic signed [bsbq_pkg::COORD_BITS-1:0] o_bound_min_y,
    output logic signed [bsbq_pkg::COORD_BITS-1:0] o_bound_min_z,
    output logic signed [bsbq_pkg::COORD_BITS-1:0] o_bound_max_x,
    output logic signed [bsbq_pkg::COORD_BITS-1:0] o_bound_max_y,
    output logic signed [bsbq_pkg::COORD_BITS-1:0] o_bound_max_z,
    output logic [bsbq_pkg::CNT_W-1:0]      o_box_count
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_PASS  = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    bsbq_pkg::t_query  r_qry;
    bsbq_pkg::t_count  r_count;
    bsbq_pkg::t_count  n_count;
    bsbq_pkg::t_vec3   r_blo;
    bsbq_pkg::t_vec3   r_bhi;
    bsbq_pkg::t_vec3   n_blo;
    bsbq_pkg::t_vec3   n_bhi;
    logic              r_valid;
    logic              n_valid;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic              r_hit;
    logic              n_hit;
    bsbq_pkg::t_coord  r_bz;
    bsbq_pkg::t_coord  n_bz;

    logic              accept;
    logic              wr;
    logic              shift;
    logic              full;
    logic              pass_done;
    bsbq_pkg::t_tok    tok_head;
    bsbq_pkg::t_tok    w_tok [bsbq_pkg::MAX_BOXES+1];
    bsbq_pkg::t_entry  w_ent [bsbq_pkg::MAX_BOXES];
    bsbq_pkg::t_entry  w_next [bsbq_pkg::MAX_BOXES];
    bsbq_pkg::t_tok    last;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign full      = (r_count == bsbq_pkg::t_count'(bsbq_pkg::MAX_BOXES));
    assign last      = w_tok[bsbq_pkg::MAX_BOXES];
    assign pass_done = (r_state == S_PASS) && last.valid;
    assign wr        = (r_state == S_ISSUE) && (r_qry.cmd == bsbq_pkg::CMD_ADD) && !full;
    assign shift     = pass_done && (r_qry.cmd == bsbq_pkg::CMD_REMOVE) && last.found;

    // launch the token into the head of the chain
    always_comb begin
        tok_head       = '0;
        tok_head.valid = (r_state == S_ISSUE) && (r_qry.cmd != bsbq_pkg::CMD_ADD);
        tok_head.bz    = r_bhi.z;
    end

    assign w_tok[0] = tok_head;

    // chain of cells, one box each
    genvar g;
    generate
        for (g = 0; g < bsbq_pkg::MAX_BOXES; g++) begin : g_cell
            if (g == bsbq_pkg::MAX_BOXES - 1) begin : g_tail
                assign w_next[g] = w_ent[g];
            end else begin : g_body
                assign w_next[g] = w_ent[g+1];
            end

            bsbq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_index      (bsbq_pkg::t_index'(g)),
                .i_count      (r_count),
                .i_qry        (r_qry),
                .i_wr         (wr),
                .i_shift      (shift),
                .i_next_entry (w_next[g]),
                .o_entry      (w_ent[g]),
                .i_tok        (w_tok[g]),
                .o_tok        (w_tok[g+1])
            );
        end
    endgenerate

    // hold the operands of the accepted command
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qry.cmd   <= i_cmd;
            r_qry.tag   <= i_part_id;
            r_qry.lo    <= '{x: i_min_x, y: i_min_y, z: i_min_z};
            r_qry.hi    <= '{x: i_max_x, y: i_max_y, z: i_max_z};
            r_qry.off   <= '{x: i_off_x, y: i_off_y, z: i_off_z};
        end
    end

    // sequence the command and form its result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_blo    = r_blo;
        n_bhi    = r_bhi;
        n_valid  = 1'b0;
        n_status = r_status;
        n_hit    = r_hit;
        n_bz     = r_bz;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_qry.cmd == bsbq_pkg::CMD_ADD) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_hit    = 1'b0;
                    n_bz     = '0;
                    if (full) begin
                        n_status = bsbq_pkg::ST_FULL;
                    end else begin
                        n_status = bsbq_pkg::ST_OK;
                        n_count  = bsbq_pkg::t_count'(r_count + bsbq_pkg::t_count'(1));
                        if (r_count == '0) begin
                            n_blo = r_qry.lo;
                            n_bhi = r_qry.hi;
                        end else begin
                            n_blo.x = bsbq_pkg::cmin(r_blo.x, r_qry.lo.x);
                            n_blo.y = bsbq_pkg::cmin(r_blo.y, r_qry.lo.y);
                            n_blo.z = bsbq_pkg::cmin(r_blo.z, r_qry.lo.z);
                            n_bhi.x = bsbq_pkg::cmax(r_bhi.x, r_qry.hi.x);
                            n_bhi.y = bsbq_pkg::cmax(r_bhi.y, r_qry.hi.y);
                            n_bhi.z = bsbq_pkg::cmax(r_bhi.z, r_qry.hi.z);
                        end
                    end
                end else begin
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                if (last.valid) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = bsbq_pkg::ST_OK;
                    n_hit    = 1'b0;
                    n_bz     = '0;
                    case (r_qry.cmd)
                        bsbq_pkg::CMD_REMOVE: begin
                            if (last.found) begin
                                n_count = bsbq_pkg::t_count'(r_count - bsbq_pkg::t_count'(1));
                            end else begin
                                n_status = bsbq_pkg::ST_NOT_FOUND;
                            end
                            n_blo = last.have ? last.lo : '0;
                            n_bhi = last.have ? last.hi : '0;
                        end
                        bsbq_pkg::CMD_BOTTOM: begin
                            n_bz = (last.bz == r_bhi.z) ? r_blo.z : last.bz;
                        end
                        bsbq_pkg::CMD_INTERSECT: begin
                            n_hit = last.hit;
                        end
                        default: begin
                            n_hit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_blo   <= '0;
            r_bhi   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_blo   <= n_blo;
            r_bhi   <= n_bhi;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_hit    <= n_hit;
        r_bz     <= n_bz;
    end

    // drive the result ports
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_hit         = r_hit;
    assign o_bottom_z    = r_bz;
    assign o_bound_min_x = r_blo.x;
    assign o_bound_min_y = r_blo.y;
    assign o_bound_min_z = r_blo.z;
    assign o_bound_max_x = r_bhi.x;
    assign o_bound_max_y = r_bhi.y;
    assign o_bound_max_z = r_bhi.z;
    assign o_box_count   = r_count;

endmodule

@@ dv/box_set_bounds_and_queries_top_test.sv @@
`timescale 1ns / 1ps

module box_set_bounds_and_queries_top_test;

    localparam int RAND_ITEMS  = 1100;
    localparam int QUIET_ITEMS = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 100;

    // one command as presented on the input ports, plus its lead-in gap
    typedef struct packed {
        logic [1:0]                 cmd;
        logic [bsbq_pkg::TAG_W-1:0] tag;
        bsbq_pkg::t_vec3            lo;
        bsbq_pkg::t_vec3            hi;
        bsbq_pkg::t_vec3            off;
        logic                       hold;
        logic [2:0]                 gap;
    } t_box_cmd;

    // predicted reply, widened to int for comparison
    typedef struct {
        int status;
        int hit;
        int bottom;
        int bmin_x, bmin_y, bmin_z;
        int bmax_x, bmax_y, bmax_z;
        int count;
    } t_box_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic [1:0]                 i_cmd     = '0;
    logic [bsbq_pkg::TAG_W-1:0] i_part_id = '0;
    bsbq_pkg::t_coord i_min_x = '0, i_min_y = '0, i_min_z = '0;
    bsbq_pkg::t_coord i_max_x = '0, i_max_y = '0, i_max_z = '0;
    bsbq_pkg::t_coord i_off_x = '0, i_off_y = '0, i_off_z = '0;
    logic             o_valid;
    logic [1:0]       o_status;
    logic             o_hit;
    bsbq_pkg::t_coord o_bottom_z;
    bsbq_pkg::t_coord o_bound_min_x, o_bound_min_y, o_bound_min_z;
    bsbq_pkg::t_coord o_bound_max_x, o_bound_max_y, o_bound_max_z;
    bsbq_pkg::t_count o_box_count;

    box_set_bounds_and_queries_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_part_id     (i_part_id),
        .i_min_x       (i_min_x),
        .i_min_y       (i_min_y),
        .i_min_z       (i_min_z),
        .i_max_x       (i_max_x),
        .i_max_y       (i_max_y),
        .i_max_z       (i_max_z),
        .i_off_x       (i_off_x),
        .i_off_y       (i_off_y),
        .i_off_z       (i_off_z),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_hit         (o_hit),
        .o_bottom_z    (o_bottom_z),
        .o_bound_min_x (o_bound_min_x),
        .o_bound_min_y (o_bound_min_y),
        .o_bound_min_z (o_bound_min_z),
        .o_bound_max_x (o_bound_max_x),
        .o_bound_max_y (o_bound_max_y),
        .o_bound_max_z (o_bound_max_z),
        .o_box_count   (o_box_count)
    );

    always #4 i_clk = ~i_clk;

    t_box_cmd   cmd_backlog[$];
    t_box_reply box_replies[$];
    logic [bsbq_pkg::TAG_W-1:0] live_tags[$];

    // shadow of the box table and bounds
    int tbl_lo[bsbq_pkg::MAX_BOXES][3];
    int tbl_hi[bsbq_pkg::MAX_BOXES][3];
    logic [bsbq_pkg::TAG_W-1:0] tbl_tag[bsbq_pkg::MAX_BOXES];
    int n_boxes = 0;
    int bnd_lo[3] = '{0, 0, 0};
    int bnd_hi[3] = '{0, 0, 0};

    int  n_errors    = 0;
    int  n_replies   = 0;
    int  stall_count = 0;
    bit  quiet_tail  = 0;
    bit  taken       = 0;
    bit  staged      = 0;
    int  gap_left    = 0;
    logic start_n;
    t_box_cmd   staged_cmd;
    t_box_cmd   cur_cmd;
    t_box_reply want;

    task automatic report_error(string msg);
        n_errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int got, int exp_val);
        if (got != exp_val)
            report_error($sformatf("reply %0d %s: got %0d, expected %0d",
                                   n_replies, name, got, exp_val));
    endtask

    // apply one command to the shadow table and work out its reply
    function automatic t_box_reply compute_reply(t_box_cmd c);
        t_box_reply r;
        int lo[3], hi[3], off[3];
        int idx, k, a, bot;
        bit found, ov;
        lo[0]  = int'(c.lo.x);  lo[1]  = int'(c.lo.y);  lo[2]  = int'(c.lo.z);
        hi[0]  = int'(c.hi.x);  hi[1]  = int'(c.hi.y);  hi[2]  = int'(c.hi.z);
        off[0] = int'(c.off.x); off[1] = int'(c.off.y); off[2] = int'(c.off.z);
        r.status = int'(bsbq_pkg::ST_OK);
        r.hit    = 0;
        bot      = 0;
        case (c.cmd)
            bsbq_pkg::CMD_ADD: begin
                if (n_boxes >= bsbq_pkg::MAX_BOXES) begin
                    r.status = int'(bsbq_pkg::ST_FULL);
                end else begin
                    for (a = 0; a < 3; a++) begin
                        if (n_boxes == 0) begin
                            bnd_lo[a] = lo[a];
                            bnd_hi[a] = hi[a];
                        end else begin
                            if (bnd_lo[a] > lo[a]) bnd_lo[a] = lo[a];
                            if (bnd_hi[a] < hi[a]) bnd_hi[a] = hi[a];
                        end
                        tbl_lo[n_boxes][a] = lo[a];
                        tbl_hi[n_boxes][a] = hi[a];
                    end
                    tbl_tag[n_boxes] = c.tag;
                    n_boxes++;
                end
            end
            bsbq_pkg::CMD_REMOVE: begin
                found = 0;
                // drop the first entry with this tag and close the gap
                for (idx = 0; idx < n_boxes && !found; idx++) begin
                    if (tbl_tag[idx] == c.tag) begin
                        for (k = idx; k < n_boxes - 1; k++) begin
                            tbl_lo[k]  = tbl_lo[k + 1];
                            tbl_hi[k]  = tbl_hi[k + 1];
                            tbl_tag[k] = tbl_tag[k + 1];
                        end
                        n_boxes--;
                        found = 1;
                    end
                end
                if (!found) r.status = int'(bsbq_pkg::ST_NOT_FOUND);
                // rebuild the bounds from what is left
                for (a = 0; a < 3; a++) begin
                    bnd_lo[a] = (n_boxes == 0) ? 0 : tbl_lo[0][a];
                    bnd_hi[a] = (n_boxes == 0) ? 0 : tbl_hi[0][a];
                    for (idx = 1; idx < n_boxes; idx++) begin
                        if (bnd_lo[a] > tbl_lo[idx][a]) bnd_lo[a] = tbl_lo[idx][a];
                        if (bnd_hi[a] < tbl_hi[idx][a]) bnd_hi[a] = tbl_hi[idx][a];
                    end
                end
            end
            bsbq_pkg::CMD_BOTTOM: begin
                bot = bnd_hi[2];
                for (idx = 0; idx < n_boxes; idx++) begin
                    if (tbl_hi[idx][0] >= lo[0] && tbl_lo[idx][0] <= hi[0] &&
                        tbl_hi[idx][1] >= lo[1] && tbl_lo[idx][1] <= hi[1] &&
                        bot > tbl_lo[idx][2])
                        bot = tbl_lo[idx][2];
                end
                if (bot == bnd_hi[2]) bot = bnd_lo[2];
            end
            default: begin
                // strict overlap against each shifted box, no wrap on the sums
                for (idx = 0; idx < n_boxes && r.hit == 0; idx++) begin
                    ov = 1;
                    for (a = 0; a < 3; a++) begin
                        if (!(tbl_lo[idx][a] + off[a] < hi[a] &&
                              tbl_hi[idx][a] + off[a] > lo[a]))
                            ov = 0;
                    end
                    if (ov) r.hit = 1;
                end
            end
        endcase
        r.bottom = bot;
        r.bmin_x = bnd_lo[0]; r.bmin_y = bnd_lo[1]; r.bmin_z = bnd_lo[2];
        r.bmax_x = bnd_hi[0]; r.bmax_y = bnd_hi[1]; r.bmax_z = bnd_hi[2];
        r.count  = n_boxes;
        return r;
    endfunction

    function automatic bsbq_pkg::t_vec3 mk(int x, int y, int z);
        bsbq_pkg::t_vec3 v;
        v.x = x[bsbq_pkg::COORD_BITS-1:0];
        v.y = y[bsbq_pkg::COORD_BITS-1:0];
        v.z = z[bsbq_pkg::COORD_BITS-1:0];
        return v;
    endfunction

    // mostly a small cluster so boxes overlap, with extremes and full-range values
    function automatic int rand_coord();
        logic [31:0]                     raw;
        logic [bsbq_pkg::COORD_BITS-1:0] w;
        raw = $urandom;
        w   = raw[bsbq_pkg::COORD_BITS-1:0];
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 32767 : -32768;
            1, 2:    return int'($signed(w));
            default: return int'($urandom_range(0, 120)) - 60;
        endcase
    endfunction

    function automatic int rand_offset();
        logic [31:0]                     raw;
        logic [bsbq_pkg::COORD_BITS-1:0] w;
        raw = $urandom;
        w   = raw[bsbq_pkg::COORD_BITS-1:0];
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 32767 : -32768;
            1, 2:    return int'($signed(w));
            default: return int'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    task automatic rand_box(output bsbq_pkg::t_vec3 lo, output bsbq_pkg::t_vec3 hi);
        int a_v[3], b_v[3], t, a;
        for (a = 0; a < 3; a++) begin
            a_v[a] = rand_coord();
            b_v[a] = rand_coord();
            if (a_v[a] > b_v[a]) begin
                t = a_v[a]; a_v[a] = b_v[a]; b_v[a] = t;
            end
        end
        // now and then an inverted box
        if ($urandom_range(0, 9) == 0) begin
            lo = mk(b_v[0], b_v[1], b_v[2]);
            hi = mk(a_v[0], a_v[1], a_v[2]);
        end else begin
            lo = mk(a_v[0], a_v[1], a_v[2]);
            hi = mk(b_v[0], b_v[1], b_v[2]);
        end
    endtask

    // queue a command and keep the list of live tags in step
    task automatic queue_cmd(logic [1:0] cmd, int tag, bsbq_pkg::t_vec3 lo,
                             bsbq_pkg::t_vec3 hi, bsbq_pkg::t_vec3 off, bit hold);
        t_box_cmd c;
        int k;
        c.cmd  = cmd;
        c.tag  = tag[bsbq_pkg::TAG_W-1:0];
        c.lo   = lo;
        c.hi   = hi;
        c.off  = off;
        c.hold = hold;
        c.gap  = (quiet_tail || $urandom_range(0, 2) != 0) ? 3'd0 : 3'($urandom_range(1, 6));
        cmd_backlog = {cmd_backlog, c};
        if (cmd == bsbq_pkg::CMD_ADD && live_tags.size() < bsbq_pkg::MAX_BOXES) begin
            live_tags = {live_tags, c.tag};
        end else if (cmd == bsbq_pkg::CMD_REMOVE) begin
            for (k = 0; k < live_tags.size(); k++) begin
                if (live_tags[k] == c.tag) begin
                    live_tags.delete(k);
                    break;
                end
            end
        end
    endtask

    // stimulus and end of run
    initial begin : stimulus
        bsbq_pkg::t_vec3 lo, hi, off;
        bsbq_pkg::t_vec3 zero3, top3, bot3;
        int i, roll, phase, tag;
        logic [1:0] cmd;
        zero3 = mk(0, 0, 0);
        top3  = mk(32767, 32767, 32767);
        bot3  = mk(-32768, -32768, -32768);

        // empty-table queries and a remove that cannot find anything
        queue_cmd(bsbq_pkg::CMD_BOTTOM, 0, bot3, top3, zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_INTERSECT, 0, bot3, top3, zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_REMOVE, 5, zero3, zero3, zero3, 1'b0);
        // full-range box, then an inverted one
        queue_cmd(bsbq_pkg::CMD_ADD, 0, bot3, top3, zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_ADD, 255, mk(100, 100, 100), mk(-100, -100, -100),
                  zero3, 1'b0);
        // offsets at both extremes; the sums must not wrap
        queue_cmd(bsbq_pkg::CMD_INTERSECT, 1, mk(0, 0, 0), mk(1, 1, 1), top3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_INTERSECT, 2, mk(-1, -1, -1), mk(0, 0, 0), bot3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_REMOVE, 0, zero3, zero3, zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_BOTTOM, 0, mk(-200, -200, 0), mk(200, 200, 0), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_INTERSECT, 3, mk(-200, -200, -200), mk(200, 200, 200),
                  zero3, 1'b0);
        // remove the last box: bounds go back to zero
        queue_cmd(bsbq_pkg::CMD_REMOVE, 255, zero3, zero3, zero3, 1'b0);
        // duplicate tags and flat boxes at the top
        queue_cmd(bsbq_pkg::CMD_ADD, 3, mk(0, 0, 0), mk(10, 10, 10), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_ADD, 3, mk(20, 20, -5), mk(30, 30, 5), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_ADD, 7, mk(0, 0, 50), mk(5, 5, 50), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_ADD, 9, mk(100, 100, 50), mk(110, 110, 50), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_BOTTOM, 0, mk(0, 0, 0), mk(10, 10, 0), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_BOTTOM, 0, mk(10, 10, 0), mk(10, 10, 0), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_BOTTOM, 0, mk(40, 40, 0), mk(50, 50, 0), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_BOTTOM, 0, mk(100, 100, 0), mk(105, 105, 0), zero3, 1'b0);
        // faces that only touch do not count; a unit shift makes them overlap
        queue_cmd(bsbq_pkg::CMD_INTERSECT, 0, mk(10, 10, 10), mk(20, 20, 20), zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_INTERSECT, 0, mk(10, 10, 10), mk(20, 20, 20), mk(1, 1, 1),
                  1'b0);
        queue_cmd(bsbq_pkg::CMD_REMOVE, 3, zero3, zero3, zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_REMOVE, 42, zero3, zero3, zero3, 1'b0);
        queue_cmd(bsbq_pkg::CMD_INTERSECT, 0, bot3, top3, bot3, 1'b0);

        // random part: fill, mixed and drain phases in turn
        for (i = 0; i < RAND_ITEMS; i++) begin
            quiet_tail = (i >= RAND_ITEMS - QUIET_ITEMS);
            phase = (i / 120) % 3;
            roll  = $urandom_range(0, 99);
            case (phase)
                0:       cmd = (roll < 80) ? bsbq_pkg::CMD_ADD :
                               (roll < 85) ? bsbq_pkg::CMD_REMOVE :
                               (roll < 93) ? bsbq_pkg::CMD_BOTTOM : bsbq_pkg::CMD_INTERSECT;
                1:       cmd = (roll < 30) ? bsbq_pkg::CMD_ADD :
                               (roll < 55) ? bsbq_pkg::CMD_REMOVE :
                               (roll < 80) ? bsbq_pkg::CMD_BOTTOM : bsbq_pkg::CMD_INTERSECT;
                default: cmd = (roll < 10) ? bsbq_pkg::CMD_ADD :
                               (roll < 75) ? bsbq_pkg::CMD_REMOVE :
                               (roll < 88) ? bsbq_pkg::CMD_BOTTOM : bsbq_pkg::CMD_INTERSECT;
            endcase
            tag = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
            if (cmd == bsbq_pkg::CMD_REMOVE && live_tags.size() > 0 &&
                $urandom_range(0, 99) < 85)
                tag = int'(live_tags[$urandom_range(0, live_tags.size() - 1)]);
            rand_box(lo, hi);
            off = mk(rand_offset(), rand_offset(), rand_offset());
            queue_cmd(cmd, tag, lo, hi, off, (i % 275) == 137);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the backlog and every reply, then let the block settle
        while (cmd_backlog.size() != 0 || staged || start || box_replies.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (box_replies.size() != 0)
            report_error($sformatf("%0d replies never arrived", box_replies.size()));
        if (n_errors == 0)
            $display("box_set_bounds_and_queries_top verification clean");
        else
            $display("box_set_bounds_and_queries_top verification failed");
        $finish;
    end

    // driver: present the next command after its gap, hold it until the transfer
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            start_n = start && !taken;
            if (!start_n) begin
                // a held command waits until every reply is back
                if (!staged && cmd_backlog.size() != 0 &&
                    (!cmd_backlog[0].hold || box_replies.size() == 0)) begin
                    staged_cmd = cmd_backlog.pop_front();
                    staged     = 1;
                    gap_left   = int'(staged_cmd.gap);
                end
                if (staged) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        staged    = 0;
                        start_n   = 1'b1;
                        cur_cmd   <= staged_cmd;
                        i_cmd     <= staged_cmd.cmd;
                        i_part_id <= staged_cmd.tag;
                        i_min_x   <= staged_cmd.lo.x;
                        i_min_y   <= staged_cmd.lo.y;
                        i_min_z   <= staged_cmd.lo.z;
                        i_max_x   <= staged_cmd.hi.x;
                        i_max_y   <= staged_cmd.hi.y;
                        i_max_z   <= staged_cmd.hi.z;
                        i_off_x   <= staged_cmd.off.x;
                        i_off_y   <= staged_cmd.off.y;
                        i_off_z   <= staged_cmd.off.z;
                    end
                end
            end
            start <= start_n;
        end
    end

    // monitor: check each reply against the oldest prediction, predict on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            taken <= 0;
        end else begin
            if (o_valid) begin
                if (box_replies.size() == 0) begin
                    report_error("reply with no command outstanding");
                end else begin
                    want = box_replies.pop_front();
                    check_field("status", int'(o_status), want.status);
                    check_field("hit", int'(o_hit), want.hit);
                    check_field("bottom_z", int'(o_bottom_z), want.bottom);
                    check_field("bound_min_x", int'(o_bound_min_x), want.bmin_x);
                    check_field("bound_min_y", int'(o_bound_min_y), want.bmin_y);
                    check_field("bound_min_z", int'(o_bound_min_z), want.bmin_z);
                    check_field("bound_max_x", int'(o_bound_max_x), want.bmax_x);
                    check_field("bound_max_y", int'(o_bound_max_y), want.bmax_y);
                    check_field("bound_max_z", int'(o_bound_max_z), want.bmax_z);
                    check_field("box_count", int'(o_box_count), want.count);
                end
                n_replies++;
            end
            if (start && !busy)
                box_replies = {box_replies, compute_reply(cur_cmd)};
            taken <= start && !busy;
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid || (start && !busy))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("ERROR @%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("box_set_bounds_and_queries_top verification failed");
                $finish;
            end
        end
    end

endmodule
